// ----- rtl/core/dbd_pkg.sv -----
// shared types, widths and constants for the day span unit
// no dependencies; imported by dbd_day_number, days_between_dates_unit and the testbench
`default_nettype none
package dbd_pkg;

   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int SPAN_W    = 22;
   localparam int DAYNUM_W  = 23;
   localparam int PREFIX_W  = 9;
   localparam int LEAPCNT_W = 12;
   localparam int CENT_W    = 8;

   // floor(x / 100) for any 14-bit x as (x * RECIP_100) >> RECIP_SHIFT
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [YEAR_W-1:0]    YEAR_BASE     = YEAR_W'(1900);
   localparam logic [LEAPCNT_W-1:0] LEAPS_BEFORE  = LEAPCNT_W'(460);
   localparam logic [DAYNUM_W-1:0]  DAYS_PER_YEAR = DAYNUM_W'(365);
   localparam logic [YEAR_W-1:0]    CENTURY       = YEAR_W'(100);
   localparam logic [MONTH_W-1:0]   MONTHS        = MONTH_W'(12);
   localparam logic [SPAN_W:0]      SPAN_MAX      = {1'b0, {SPAN_W{1'b1}}};

   // per-stage load enables of the date pipeline
   typedef struct packed {
      logic en_s1;
      logic en_s2;
      logic en_s3;
   } pipe_ctl_type;

   // days before the month in a common year, by months passed
   function automatic logic [PREFIX_W-1:0] month_prefix(input logic [MONTH_W-1:0] passed);
      logic [PREFIX_W-1:0] days;
      case (passed)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         4'd11:   days = 9'd334;
         default: days = 9'd365;
      endcase
      return days;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/days_between_dates_unit.sv -----
// top level of the day span unit: handshake, valid pipeline, span stage
// depends on dbd_pkg and dbd_day_number
`default_nettype none
// Takes a pair of Gregorian dates per word and returns the inclusive day
// span between them, saturated at 22 bits. Fully pipelined: one word per
// clock while the result side is not stalled, in four register stages. Three
// stages form each date's day number (reciprocal multiply for the century
// quotients, leap and month arithmetic, final sum), the fourth takes the
// absolute difference. Each stage holds its word while the next is full and
// stalled, so bubbles close up and a stalled result does not block the input
// until the pipeline is full.
module days_between_dates_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [dbd_pkg::YEAR_W-1:0]    req_start_year,
   input  wire logic [dbd_pkg::MONTH_W-1:0]   req_start_month,
   input  wire logic [dbd_pkg::DAY_W-1:0]     req_start_day,
   input  wire logic [dbd_pkg::YEAR_W-1:0]    req_end_year,
   input  wire logic [dbd_pkg::MONTH_W-1:0]   req_end_month,
   input  wire logic [dbd_pkg::DAY_W-1:0]     req_end_day,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [dbd_pkg::SPAN_W-1:0]    rsp_day_span
);
   import dbd_pkg::*;

   logic         v1_ff, v2_ff, v3_ff, v4_ff;
   logic         rdy1, rdy2, rdy3, rdy4;
   pipe_ctl_type ctl;

   assign rdy4 = !v4_ff || !rsp_stall;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign ctl.en_s1 = rdy1;
   assign ctl.en_s2 = rdy2;
   assign ctl.en_s3 = rdy3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   logic [DAYNUM_W-1:0] start_num;
   logic [DAYNUM_W-1:0] end_num;

   dbd_day_number u_start (
      .clock   (clock),
      .ctl     (ctl),
      .year    (req_start_year),
      .month   (req_start_month),
      .day     (req_start_day),
      .day_num (start_num)
   );

   dbd_day_number u_end (
      .clock   (clock),
      .ctl     (ctl),
      .year    (req_end_year),
      .month   (req_end_month),
      .day     (req_end_day),
      .day_num (end_num)
   );

   // absolute difference plus one, clipped to the field
   logic [DAYNUM_W-1:0] diff;
   logic [DAYNUM_W:0]   span_full;
   logic [SPAN_W-1:0]   span_in, span_ff;

   always_comb begin
      if (start_num > end_num) begin
         diff = start_num - end_num;
      end else begin
         diff = end_num - start_num;
      end
      span_full = (DAYNUM_W+1)'(diff) + (DAYNUM_W+1)'(1);
      if (span_full > (DAYNUM_W+1)'(SPAN_MAX)) begin
         span_in = SPAN_MAX[SPAN_W-1:0];
      end else begin
         span_in = span_full[SPAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         span_ff <= span_in;
      end
   end

   assign req_stall    = !rdy1;
   assign rsp_valid    = v4_ff;
   assign rsp_day_span = span_ff;

endmodule
`default_nettype wire

// ----- rtl/core/dbd_day_number.sv -----
// three-stage pipeline turning one date into its day number from 1900
// depends on dbd_pkg
`default_nettype none
module dbd_day_number (
   input  wire logic                          clock,
   input  wire dbd_pkg::pipe_ctl_type         ctl,
   input  wire logic [dbd_pkg::YEAR_W-1:0]    year,
   input  wire logic [dbd_pkg::MONTH_W-1:0]   month,
   input  wire logic [dbd_pkg::DAY_W-1:0]     day,
   output logic      [dbd_pkg::DAYNUM_W-1:0]  day_num
);
   import dbd_pkg::*;

   // stage 1: century quotients by reciprocal multiply
   logic [YEAR_W-1:0]           year_prev;
   logic [YEAR_W+12:0]          prod_prev;
   logic [YEAR_W+12:0]          prod_year;
   logic [CENT_W-1:0]           cent_prev_in, cent_prev_ff;
   logic [CENT_W-1:0]           cent_year_in, cent_year_ff;
   logic [YEAR_W-1:0]           year_s1_ff;
   logic [MONTH_W-1:0]          month_s1_ff;
   logic [DAY_W-1:0]            day_s1_ff;

   assign year_prev    = year - YEAR_W'(1);
   assign prod_prev    = (YEAR_W+13)'(year_prev) * (YEAR_W+13)'(RECIP_100);
   assign prod_year    = (YEAR_W+13)'(year) * (YEAR_W+13)'(RECIP_100);
   assign cent_prev_in = prod_prev[RECIP_SHIFT +: CENT_W];
   assign cent_year_in = prod_year[RECIP_SHIFT +: CENT_W];

   always_ff @(posedge clock) begin
      if (ctl.en_s1) begin
         cent_prev_ff <= cent_prev_in;
         cent_year_ff <= cent_year_in;
         year_s1_ff   <= year;
         month_s1_ff  <= month;
         day_s1_ff    <= day;
      end
   end

   // stage 2: leap count, year days, month prefix
   logic [YEAR_W-1:0]           prev_s1;
   logic [YEAR_W-1:0]           year_off;
   logic [YEAR_W-1:0]           cent_rem;
   logic                        is_leap;
   logic [MONTH_W-1:0]          passed;
   logic                        after_base_in, after_base_ff;
   logic [DAYNUM_W-1:0]         year_days_in, year_days_ff;
   logic [LEAPCNT_W-1:0]        leaps_in, leaps_ff;
   logic [PREFIX_W-1:0]         month_days_in, month_days_ff;
   logic [DAY_W-1:0]            day_s2_ff;

   always_comb begin
      prev_s1       = year_s1_ff - YEAR_W'(1);
      year_off      = year_s1_ff - YEAR_BASE;
      after_base_in = (year_s1_ff > YEAR_BASE);
      year_days_in  = DAYNUM_W'(year_off) * DAYS_PER_YEAR;
      // n/4 - n/100 + n/400 with n the year before
      leaps_in      = LEAPCNT_W'(prev_s1[YEAR_W-1:2]) - LEAPCNT_W'(cent_prev_ff)
                    + LEAPCNT_W'(cent_prev_ff[CENT_W-1:2]);
      cent_rem      = year_s1_ff - YEAR_W'(YEAR_W'(cent_year_ff) * CENTURY);
      is_leap       = (year_s1_ff[1:0] == 2'b00)
                    && ((cent_rem != '0) || (cent_year_ff[1:0] == 2'b00));
      if (month_s1_ff == '0) begin
         passed = '0;
      end else if ((month_s1_ff - MONTH_W'(1)) > MONTHS) begin
         passed = MONTHS;
      end else begin
         passed = month_s1_ff - MONTH_W'(1);
      end
      month_days_in = month_prefix(passed)
                    + PREFIX_W'((passed >= MONTH_W'(2)) && is_leap);
   end

   always_ff @(posedge clock) begin
      if (ctl.en_s2) begin
         after_base_ff <= after_base_in;
         year_days_ff  <= year_days_in;
         leaps_ff      <= leaps_in;
         month_days_ff <= month_days_in;
         day_s2_ff     <= day_s1_ff;
      end
   end

   // stage 3: final sum
   logic [DAYNUM_W-1:0] year_part;
   logic [DAYNUM_W-1:0] day_num_in, day_num_ff;

   always_comb begin
      if (after_base_ff) begin
         year_part = year_days_ff + DAYNUM_W'(leaps_ff) - DAYNUM_W'(LEAPS_BEFORE);
      end else begin
         year_part = '0;
      end
      day_num_in = year_part + DAYNUM_W'(month_days_ff) + DAYNUM_W'(day_s2_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.en_s3) begin
         day_num_ff <= day_num_in;
      end
   end

   assign day_num = day_num_ff;

endmodule
`default_nettype wire

// ----- tb/sv/days_between_dates_unit_tb.sv -----
// self-checking testbench for days_between_dates_unit: directed table, then random date pairs
// depends on dbd_pkg and the rtl top level; spans predicted here and compared word by word
`timescale 1ns / 1ps
module days_between_dates_unit_tb;
   import dbd_pkg::*;

   typedef struct packed {
      logic [YEAR_W-1:0]  start_year;
      logic [MONTH_W-1:0] start_month;
      logic [DAY_W-1:0]   start_day;
      logic [YEAR_W-1:0]  end_year;
      logic [MONTH_W-1:0] end_month;
      logic [DAY_W-1:0]   end_day;
   } date_pair_type;

   // span_known set where the span is typed in, else the predictor supplies it
   typedef struct packed {
      date_pair_type     dates;
      logic              span_known;
      logic [SPAN_W-1:0] span;
   } span_row_type;

   localparam int RANDOM_PAIRS = 1530;
   localparam int HOLD_START   = 300;
   localparam int HOLD_CYCLES  = 120;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   date_pair_type     req_dates;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [SPAN_W-1:0] rsp_day_span;

   logic [SPAN_W-1:0] pending_spans[$];
   int                span_errors = 0;
   int                burst_left = 0;

   // days before each month of a common year, by months passed
   int unsigned days_before_month[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                          304, 334, 365};

   span_row_type directed_rows[0:19] = '{
      '{'{14'd1900, 4'd1, 5'd1, 14'd1900, 4'd1, 5'd1}, 1'b1, 22'd1},
      '{'{14'd0, 4'd0, 5'd0, 14'd0, 4'd0, 5'd0}, 1'b1, 22'd1},
      '{'{14'd16383, 4'd15, 5'd31, 14'd0, 4'd0, 5'd0}, 1'b1, 22'd4194303},
      '{'{14'd0, 4'd0, 5'd0, 14'd16383, 4'd15, 5'd31}, 1'b1, 22'd4194303},
      '{'{14'd1900, 4'd1, 5'd1, 14'd1901, 4'd1, 5'd1}, 1'b1, 22'd366},
      // years before 1900 add nothing
      '{'{14'd1850, 4'd6, 5'd15, 14'd1899, 4'd6, 5'd15}, 1'b1, 22'd1},
      // month zero counts like january
      '{'{14'd1950, 4'd0, 5'd10, 14'd1950, 4'd1, 5'd10}, 1'b1, 22'd1},
      // months past twelve all count as a whole year
      '{'{14'd2001, 4'd13, 5'd5, 14'd2001, 4'd15, 5'd5}, 1'b1, 22'd1},
      '{'{14'd2001, 4'd13, 5'd5, 14'd2002, 4'd1, 5'd5}, 1'b0, 22'd0},
      '{'{14'd2000, 4'd3, 5'd1, 14'd2000, 4'd2, 5'd28}, 1'b0, 22'd0},
      '{'{14'd1900, 4'd3, 5'd1, 14'd1900, 4'd2, 5'd28}, 1'b0, 22'd0},
      '{'{14'd2100, 4'd3, 5'd1, 14'd2100, 4'd2, 5'd29}, 1'b0, 22'd0},
      '{'{14'd2400, 4'd12, 5'd31, 14'd2400, 4'd1, 5'd1}, 1'b0, 22'd0},
      // day past the month's length is taken as given
      '{'{14'd2024, 4'd2, 5'd31, 14'd2024, 4'd3, 5'd2}, 1'b0, 22'd0},
      '{'{14'd9999, 4'd12, 5'd31, 14'd1900, 4'd1, 5'd1}, 1'b0, 22'd0},
      '{'{14'd1, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31}, 1'b0, 22'd0},
      '{'{14'd1899, 4'd12, 5'd31, 14'd1900, 4'd1, 5'd1}, 1'b0, 22'd0},
      '{'{14'd1901, 4'd1, 5'd1, 14'd1900, 4'd12, 5'd31}, 1'b0, 22'd0},
      '{'{14'd12000, 4'd5, 5'd5, 14'd1, 4'd2, 5'd3}, 1'b0, 22'd0},
      '{'{14'd10922, 4'd10, 5'd21, 14'd5461, 4'd5, 5'd10}, 1'b0, 22'd0}
   };

   days_between_dates_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_year  (req_dates.start_year),
      .req_start_month (req_dates.start_month),
      .req_start_day   (req_dates.start_day),
      .req_end_year    (req_dates.end_year),
      .req_end_month   (req_dates.end_month),
      .req_end_day     (req_dates.end_day),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_day_span    (rsp_day_span)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned leaps_through(int unsigned n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   function automatic int unsigned day_count(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
                                             logic [DAY_W-1:0] dy);
      int unsigned y;
      int unsigned passed;
      int unsigned days;
      bit          leap;
      y = yr;
      days = 0;
      if (y > 1900) begin
         days = 365 * (y - 1900) + leaps_through(y - 1) - leaps_through(1899);
      end
      passed = (mo == 0) ? 0 : mo - 1;
      if (passed > 12) passed = 12;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      days += days_before_month[passed];
      if (passed >= 2 && leap) days += 1;
      return days + dy;
   endfunction

   function automatic logic [SPAN_W-1:0] inclusive_span(date_pair_type p);
      int unsigned a;
      int unsigned b;
      int unsigned span;
      a = day_count(p.start_year, p.start_month, p.start_day);
      b = day_count(p.end_year, p.end_month, p.end_day);
      span = ((a > b) ? a - b : b - a) + 1;
      if (span > SPAN_MAX) span = SPAN_MAX;
      return span[SPAN_W-1:0];
   endfunction

   function automatic logic [YEAR_W-1:0] pick_year();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return YEAR_W'($urandom_range(1800, 2200));
      if (sel < 9) return YEAR_W'($urandom_range(0, 9999));
      return YEAR_W'($urandom_range(10000, 16383));
   endfunction

   function automatic date_pair_type random_pair();
      date_pair_type p;
      int unsigned   kind;
      int unsigned   corner[8] = '{0, 1899, 1900, 1901, 2000, 2100, 9999, 16383};
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         // plausible dates
         p.start_year  = pick_year();
         p.start_month = MONTH_W'($urandom_range(1, 12));
         p.start_day   = DAY_W'($urandom_range(1, 31));
         p.end_year    = pick_year();
         p.end_month   = MONTH_W'($urandom_range(1, 12));
         p.end_day     = DAY_W'($urandom_range(1, 31));
      end else if (kind < 85) begin
         p = date_pair_type'({$urandom(), $urandom()});
      end else begin
         p.start_year  = YEAR_W'(corner[$urandom_range(0, 7)]);
         p.start_month = MONTH_W'($urandom_range(0, 15));
         p.start_day   = DAY_W'($urandom_range(0, 31));
         p.end_year    = YEAR_W'(corner[$urandom_range(0, 7)]);
         p.end_month   = MONTH_W'($urandom_range(0, 15));
         p.end_day     = DAY_W'($urandom_range(0, 31));
      end
      return p;
   endfunction

   // entered and left at a falling edge
   task automatic send_pair(date_pair_type p, logic [SPAN_W-1:0] span);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 40);
      end
      req_valid = 1'b1;
      req_dates = p;
      do @(posedge clock); while (req_stall);
      pending_spans.push_back(span);
      burst_left--;
      @(negedge clock);
   endtask

   initial begin : stimulus
      date_pair_type p;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_dates = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed_rows[i]) begin
         send_pair(directed_rows[i].dates,
                   directed_rows[i].span_known ? directed_rows[i].span
                                               : inclusive_span(directed_rows[i].dates));
      end
      repeat (RANDOM_PAIRS) begin
         p = random_pair();
         send_pair(p, inclusive_span(p));
      end
      req_valid = 1'b0;
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (span_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // receiver stall pattern, with one long hold-off to back the pipeline up
   initial begin : result_stall
      int cycle;
      int mode;
      int mode_left;
      cycle = 0;
      mode = 0;
      mode_left = 0;
      rsp_stall = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         cycle++;
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(5, 80);
         end
         mode_left--;
         if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES) begin
            rsp_stall = 1'b1;
         end else begin
            case (mode)
               0: begin
                  rsp_stall = 1'b0;
               end
               1: begin
                  rsp_stall = ($urandom_range(0, 3) == 0);
               end
               2: begin
                  rsp_stall = ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_stall = cycle[0];
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      logic [SPAN_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_spans.size() == 0) begin
            $error("result word with nothing expected: day_span %0d", rsp_day_span);
            span_errors++;
         end else begin
            want = pending_spans.pop_front();
            if (rsp_day_span !== want) begin
               $error("day_span mismatch: expected %0d, actual %0d", want, rsp_day_span);
               span_errors++;
            end
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
